FILE: hdl/srig_pkg.sv
package srig_pkg;

    // Sizes
    localparam int MAX_LENGTH = 1024;
    localparam int MAX_SPREAD = 16;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
    localparam int SPR_W      = $clog2(MAX_SPREAD + 1);
    localparam int RCN_W      = $clog2(MAX_SPREAD);
    localparam int DRAW_W     = 15;
    localparam int DCNT_W     = $clog2(DRAW_W);
    localparam int CIDX_W     = 2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SPREAD_LIMIT = 2'd1;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_BLOCK_LENGTH = LEN_W'(1024);
    localparam logic [SPR_W-1:0] RST_SPREAD_LIMIT = SPR_W'(3);

    typedef struct packed {
        logic [DRAW_W-1:0] random_draw;
        logic              restart;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] position;
        logic [ADDR_W-1:0] mapped_value;
        logic              last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic div_step;
        logic rd_issue;
        logic rd_take;
        logic chk_step;
        logic emit;
        logic fill_step;
        logic shift_step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_restart;
        logic gen_live;
        logic run_restart;
        logic div_last;
        logic chk_done;
        logic chk_fail;
        logic out_free;
        logic last_hit;
        logic fill_done;
        logic shift_done;
    } t_sts;

endpackage

FILE: hdl/s_random_interleaver_generator_top.sv
// S-random interleaver pattern generator.
// Input channel (i_in_valid / o_in_ready) takes one item: a random draw
// and a restart flag. A restart begins a new pattern of block_length
// positions with spread spread_limit, both latched at that restart.
// Output channel (o_out_valid / i_out_ready) gives position, value and
// last for every accepted pick; a rejected draw gives nothing.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we.
// Steps per item: capture, a restoring division of the draw (one quotient bit
// per cycle), a pool read, a look-back against up to spread_limit recent
// picks, emit, and an order-preserving pool shift, which has nothing to move
// when the pick was the last pool entry; the last pick of a block has no shift.
// A restart skips the pool read and look-back, and reloads the pool after emit.
// The pool RAM port (one read, one write per cycle) sets the shift rate.
// The result register holds a waiting item while the next item is taken;
// a stalled receiver only holds the block at its next emission.
// Reset clears control state: no pattern, registers back to 1024 and 3.
module s_random_interleaver_generator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srig_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [srig_pkg::LEN_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  srig_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output srig_pkg::t_out_item         o_out_item
);
    import srig_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    srig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    srig_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );
endmodule

FILE: hdl/srig_ram.sv
module srig_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/srig_ctrl.sv
module srig_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  srig_pkg::t_sts i_sts,
    output srig_pkg::t_cmd o_cmd
);
    import srig_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_RDW   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;
    localparam logic [2:0] S_SHIFT = 3'd7;

    logic [2:0] r_state, n_state;
    logic       w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.in_restart || i_sts.gen_live) n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = i_sts.run_restart ? S_EMIT : S_RD;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RDW;
            end
            S_RDW: begin
                o_cmd.rd_take = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.chk_done)      n_state = S_EMIT;
                else if (i_sts.chk_fail) n_state = S_IDLE;
                else                     o_cmd.chk_step = 1'b1;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.run_restart)  n_state = S_FILL;
                    else if (i_sts.last_hit) n_state = S_IDLE;
                    else                    n_state = S_SHIFT;
                end
            end
            S_FILL: begin
                if (i_sts.fill_done) n_state = S_IDLE;
                else                 o_cmd.fill_step = 1'b1;
            end
            S_SHIFT: begin
                if (i_sts.shift_done) n_state = S_IDLE;
                else                  o_cmd.shift_step = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An item is only taken while idle
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> r_state == S_IDLE)
        else $error("capture outside idle");
    // Emission only with a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("emit while output busy");
    // A restart always reaches emission after the division
    a_restart_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last && i_sts.run_restart) |=> r_state == S_EMIT)
        else $error("restart skipped emit");
endmodule

FILE: hdl/srig_dp.sv
module srig_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srig_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [srig_pkg::LEN_W-1:0]    i_cfg_data,
    input  srig_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output srig_pkg::t_out_item           o_out_item,
    input  srig_pkg::t_cmd                i_cmd,
    output srig_pkg::t_sts                o_sts
);
    import srig_pkg::*;

    // Config and run registers
    logic [LEN_W-1:0]  r_cfg_len;
    logic [SPR_W-1:0]  r_cfg_spr;
    logic [LEN_W-1:0]  r_len, w_len_c;
    logic [SPR_W-1:0]  r_spr, w_spr_c;
    logic [LEN_W-1:0]  r_fc;
    logic              r_gen;
    logic              r_restart;
    // Division
    logic [DRAW_W-1:0] r_dq;
    logic [LEN_W-1:0]  r_rem, r_div;
    logic [DCNT_W-1:0] r_dcnt;
    logic [LEN_W:0]    w_t;
    // Check
    logic [ADDR_W-1:0] r_cand;
    logic [SPR_W-1:0]  r_k;
    logic [ADDR_W-1:0] w_prev, w_d;
    logic [RCN_W-1:0]  w_ridx;
    logic [ADDR_W-1:0] r_recent [MAX_SPREAD];
    // Pool sweep
    logic [LEN_W-1:0]  r_sh, r_cnt;
    logic [ADDR_W-1:0] r_wa;
    logic              r_pend;
    logic              r_ov;
    t_out_item         r_out;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_wdata, w_raddr, w_rdata;
    logic [ADDR_W-1:0] w_val;
    logic              w_last;

    // Clamped register values
    always_comb begin
        w_len_c = r_cfg_len;
        if (r_cfg_len == '0) w_len_c = LEN_W'(1);
        else if (r_cfg_len > LEN_W'(MAX_LENGTH)) w_len_c = LEN_W'(MAX_LENGTH);
        w_spr_c = r_cfg_spr;
        if (r_cfg_spr == '0) w_spr_c = SPR_W'(1);
        else if (r_cfg_spr > SPR_W'(MAX_SPREAD)) w_spr_c = SPR_W'(MAX_SPREAD);
    end

    // Restoring division step
    assign w_t = {r_rem, r_dq[DRAW_W-1]};

    // Look-back compare
    assign w_ridx = RCN_W'(r_fc - LEN_W'(1) - LEN_W'(r_k));
    assign w_prev = r_recent[w_ridx];
    assign w_d    = (r_cand > w_prev) ? (r_cand - w_prev) : (w_prev - r_cand);

    assign w_val  = r_restart ? r_rem[ADDR_W-1:0] : r_cand;
    assign w_last = (r_fc + LEN_W'(1)) >= r_len;

    // Configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= RST_BLOCK_LENGTH;
            r_cfg_spr <= RST_SPREAD_LIMIT;
            r_len     <= LEN_W'(1);
            r_spr     <= SPR_W'(1);
            r_fc      <= '0;
            r_gen     <= 1'b0;
            r_ov      <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_BLOCK_LENGTH) r_cfg_len <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_SPREAD_LIMIT) r_cfg_spr <= i_cfg_data[SPR_W-1:0];
            if (i_cmd.capture && i_in_item.restart) begin
                r_len <= w_len_c;
                r_spr <= w_spr_c;
                r_fc  <= '0;
                r_gen <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
                r_fc <= r_fc + LEN_W'(1);
                if (w_last) r_gen <= 1'b0;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pend <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_pend <= (r_sh < r_cnt);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_restart <= i_in_item.restart;
            r_dq      <= i_in_item.random_draw;
            r_rem     <= '0;
            r_dcnt    <= '0;
            r_div     <= i_in_item.restart ? w_len_c : (r_len - r_fc);
        end
        if (i_cmd.div_step) begin
            r_dq   <= {r_dq[DRAW_W-2:0], 1'b0};
            r_dcnt <= r_dcnt + DCNT_W'(1);
            if (w_t >= {1'b0, r_div}) r_rem <= LEN_W'(w_t - {1'b0, r_div});
            else                      r_rem <= LEN_W'(w_t);
        end
        if (i_cmd.rd_take) begin
            r_cand <= w_rdata;
            r_k    <= '0;
        end
        if (i_cmd.chk_step) r_k <= r_k + SPR_W'(1);
        if (i_cmd.emit) begin
            r_out.position     <= r_fc[ADDR_W-1:0];
            r_out.mapped_value <= w_val;
            r_out.last         <= w_last;
            r_recent[r_fc[RCN_W-1:0]] <= w_val;
            // fill counts entries to write, shift counts the old pool size
            r_sh  <= r_restart ? '0 : (r_rem + LEN_W'(1));
            r_cnt <= r_restart ? (r_len - LEN_W'(1)) : (r_len - r_fc);
        end
        if (i_cmd.fill_step) r_sh <= r_sh + LEN_W'(1);
        if (i_cmd.shift_step && r_sh < r_cnt) begin
            r_sh <= r_sh + LEN_W'(1);
            r_wa <= ADDR_W'(r_sh - LEN_W'(1));
        end
    end

    // Pool memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wa;
        w_wdata = w_rdata;
        w_raddr = r_sh[ADDR_W-1:0];
        if (i_cmd.rd_issue) w_raddr = r_rem[ADDR_W-1:0];
        if (i_cmd.fill_step) begin
            w_we    = 1'b1;
            w_waddr = r_sh[ADDR_W-1:0];
            w_wdata = (r_sh < r_rem) ? r_sh[ADDR_W-1:0] : ADDR_W'(r_sh + LEN_W'(1));
        end else if (i_cmd.shift_step && r_pend) begin
            w_we = 1'b1;
        end
    end

    srig_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LENGTH)) u_pool (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Status
    assign o_sts.in_restart  = i_in_item.restart;
    assign o_sts.gen_live    = r_gen && (r_fc < r_len);
    assign o_sts.run_restart = r_restart;
    assign o_sts.div_last    = (r_dcnt == DCNT_W'(DRAW_W - 1));
    assign o_sts.chk_done    = (r_k >= r_spr) || (LEN_W'(r_k) >= r_fc);
    assign o_sts.chk_fail    = ({{(ADDR_W-SPR_W){1'b0}}, r_spr} > w_d);
    assign o_sts.out_free    = !r_ov || i_out_ready;
    assign o_sts.last_hit    = w_last;
    assign o_sts.fill_done   = (r_sh >= r_cnt);
    assign o_sts.shift_done  = (r_sh >= r_cnt) && !r_pend;

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= r_len)
        else $error("fill count beyond length");
    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_restart) |=> r_fc == LEN_W'(1))
        else $error("restart did not fill position zero");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0 && r_len <= LEN_W'(MAX_LENGTH))
        else $error("run length out of range");
endmodule
